FILE: design/tdmast_pkg.sv
// ----------------------------------------------------------------------------
// tdmast_pkg
// shared widths, constants, command/status types and the slot number decode
// ----------------------------------------------------------------------------
package tdmast_pkg;

  localparam int TIME_W     = 64;
  localparam int REG_W      = 32;
  localparam int OFF_W      = 32;
  localparam int SLOT_COUNT = 4320;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(TIME_W);

  localparam int TSLOTS     = 4;
  localparam int FRAMES     = 18;
  localparam int RECIP_SH   = 16;
  localparam int RECIP18    = (2**RECIP_SH + FRAMES - 1) / FRAMES;

  localparam logic [IDX_W:0]   SLOT_COUNT_X = (IDX_W+1)'(SLOT_COUNT);
  localparam logic [IDX_W-1:0] SLOT_LAST    = IDX_W'(SLOT_COUNT - 1);

  localparam logic [REG_W-1:0] PERIOD_RESET = 32'd14166666;
  localparam logic [REG_W-1:0] LEAD_RESET   = 32'd12500000;

  // register indexes
  localparam logic REG_PERIOD = 1'b0;
  localparam logic REG_LEAD   = 1'b1;

  // input command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_RX   = 1'b1;

  typedef struct packed {
    logic [2:0] timeslot;
    logic [4:0] frame;
    logic [5:0] multiframe;
  } slot_num_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic tick_diff;
    logic tick_issue;
    logic rx_diff;
    logic rx_setup;
    logic div_step;
    logic rx_round;
    logic rx_slot;
    logic decode;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_rx;
    logic div_last;
    logic out_free;
  } dp_status_t;

  // slot index to one-based timeslot, frame and multiframe numbers
  // frame and multiframe come from a reciprocal multiply by 1/18 on idx/4
  function automatic slot_num_t slot_decode(logic [IDX_W-1:0] idx);
    logic [15:0] x;
    logic [31:0] prod;
    logic [15:0] q18;
    logic [15:0] fr;
    slot_num_t   n;
    x          = 16'(idx >> 2);
    prod       = 32'(x) * 32'(RECIP18);
    q18        = prod[31:16];
    fr         = x - 16'(q18 * 16'(FRAMES));
    n.timeslot = 3'(idx[1:0]) + 3'd1;
    n.frame    = 5'(fr) + 5'd1;
    n.multiframe = 6'(q18 + 16'd1);
    return n;
  endfunction

endpackage

FILE: design/tdma_slot_timing_tracker_unit.sv
// ----------------------------------------------------------------------------
// tdma_slot_timing_tracker_unit
// tdma slot timing tracker: transmit slot issue and receive burst matching
// ----------------------------------------------------------------------------
// keeps the start time of the next transmit slot and its index within a span
// of slot_count timeslots. a tick request (tuser 0) starts timing on first use
// and issues the pending slot once now plus the lead time reaches it; a
// receive request (tuser 1) is matched to the nearest slot boundary with the
// offset rounded half away from zero. one request is worked at a time: a tick
// result passes the diff, issue and decode states; a receive result passes
// diff, setup, the 64-step bit-serial divider of the timestamp difference by
// the period, round, slot and decode; an earlier result still held adds its
// wait. results sit in an output register, so the next request is taken while
// one waits. the user must write configuration only while idle; unenforced.
module tdma_slot_timing_tracker_unit (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [tdmast_pkg::REG_W-1:0]      cfg_data,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [63:0]                       s_axis_tdata,  // now_ns[63:0]
  input  logic [0:0]                        s_axis_tuser,  // command[0]
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // slot_start_ns[63:0], offset_ns[95:64], timeslot_number[98:96],
  // frame_number[103:99], multiframe_number[109:104], zero[111:110]
  output logic [111:0]                      m_axis_tdata,
  output logic [0:0]                        m_axis_tuser   // slot_issued[0]
);

  tdmast_pkg::dp_cmd_t    cmd;
  tdmast_pkg::dp_status_t status;

  logic                              out_issued;
  logic [tdmast_pkg::TIME_W-1:0]     out_start;
  logic [tdmast_pkg::OFF_W-1:0]      out_offset;
  tdmast_pkg::slot_num_t             out_num;

  // sequencer
  tdmast_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // slot state, divider and output register
  tdmast_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_cmd     (s_axis_tuser[0]),
    .in_now     (s_axis_tdata),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_issued (out_issued),
    .out_start  (out_start),
    .out_offset (out_offset),
    .out_num    (out_num),
    .cmd        (cmd),
    .status     (status)
  );

  // pack the result, first field in the lowest bits
  assign m_axis_tuser = out_issued;
  assign m_axis_tdata = {2'b00, out_num.multiframe, out_num.frame, out_num.timeslot,
                         out_offset, out_start};

endmodule

FILE: design/tdmast_ctrl.sv
// ----------------------------------------------------------------------------
// tdmast_ctrl
// sequencer for tick and receive requests, drives the datapath commands
// ----------------------------------------------------------------------------
module tdmast_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tdmast_pkg::dp_status_t status,
  output tdmast_pkg::dp_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_TDIFF  = 4'd1;
  localparam logic [3:0] S_TISSUE = 4'd2;
  localparam logic [3:0] S_RDIFF  = 4'd3;
  localparam logic [3:0] S_RSETUP = 4'd4;
  localparam logic [3:0] S_RDIV   = 4'd5;
  localparam logic [3:0] S_RROUND = 4'd6;
  localparam logic [3:0] S_RSLOT  = 4'd7;
  localparam logic [3:0] S_DECODE = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RDIFF;
        end
      end
      // captured command is visible in the state after the load
      S_RDIFF: begin
        if (status.is_rx == tdmast_pkg::CMD_RX) begin
          cmd.rx_diff = 1'b1;
          state_next  = S_RSETUP;
        end else begin
          cmd.tick_diff = 1'b1;
          state_next    = S_TISSUE;
        end
      end
      S_TDIFF: begin
        cmd.tick_diff = 1'b1;
        state_next    = S_TISSUE;
      end
      S_TISSUE: begin
        cmd.tick_issue = 1'b1;
        state_next     = S_DECODE;
      end
      S_RSETUP: begin
        cmd.rx_setup = 1'b1;
        state_next   = S_RDIV;
      end
      S_RDIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_RROUND;
        end
      end
      S_RROUND: begin
        cmd.rx_round = 1'b1;
        state_next   = S_RSLOT;
      end
      S_RSLOT: begin
        cmd.rx_slot = 1'b1;
        state_next  = S_DECODE;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/tdmast_dp.sv
// ----------------------------------------------------------------------------
// tdmast_dp
// slot time state, tick test, bit-serial divider, rounding and output register
// ----------------------------------------------------------------------------
module tdmast_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [tdmast_pkg::REG_W-1:0]        cfg_data,
  input  logic                                in_cmd,
  input  logic [tdmast_pkg::TIME_W-1:0]       in_now,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                out_issued,
  output logic [tdmast_pkg::TIME_W-1:0]       out_start,
  output logic [tdmast_pkg::OFF_W-1:0]        out_offset,
  output tdmast_pkg::slot_num_t               out_num,
  input  tdmast_pkg::dp_cmd_t                 cmd,
  output tdmast_pkg::dp_status_t              status
);

  localparam int TW = tdmast_pkg::TIME_W;
  localparam int RW = tdmast_pkg::REG_W;
  localparam int IW = tdmast_pkg::IDX_W;

  logic [RW-1:0]  period;
  logic [RW-1:0]  lead;
  logic [TW-1:0]  nst;
  logic [IW-1:0]  idx;

  logic           cmd_r;
  logic [TW-1:0]  now_r;
  logic [TW-1:0]  d_r;
  logic           neg_r;
  logic [TW-1:0]  mag_r;
  logic [TW-1:0]  div_sh;
  logic [RW-1:0]  rem;
  logic [IW-1:0]  qm;
  logic [tdmast_pkg::CNT_W-1:0] cnt;
  logic           off_neg_r;
  logic [TW-1:0]  off_mag_r;

  logic           res_issued;
  logic [TW-1:0]  res_start;
  logic [RW-1:0]  res_off;
  logic [IW-1:0]  slot_r;
  tdmast_pkg::slot_num_t res_num;

  // combinational helpers
  logic [TW-1:0]  eff_time;
  logic [TW-1:0]  lead_sum;
  logic           go;
  logic [RW:0]    rem_s;
  logic           rem_ge;
  logic [IW:0]    qm_dbl;
  logic [IW-1:0]  qm_next;
  logic [RW:0]    rem_dbl;
  logic [IW:0]    slot_add;
  logic [IW:0]    slot_sub;
  logic [IW-1:0]  slot_val;
  logic           sat_neg;
  logic [RW-1:0]  sat_val;

  assign eff_time = (nst == '0) ? now_r : nst;
  assign lead_sum = d_r + TW'(lead);
  assign go       = !d_r[TW-1] || !lead_sum[TW-1];

  assign rem_s   = {rem, div_sh[TW-1]};
  assign rem_ge  = rem_s >= {1'b0, period};
  assign qm_dbl  = {qm, 1'b0} + (IW+1)'(rem_ge);
  assign qm_next = (qm_dbl >= tdmast_pkg::SLOT_COUNT_X) ?
                   IW'(qm_dbl - tdmast_pkg::SLOT_COUNT_X) : IW'(qm_dbl);
  assign rem_dbl = {rem, 1'b0};

  assign slot_add = {1'b0, idx} + {1'b0, qm};
  assign slot_sub = {1'b0, idx} - {1'b0, qm};
  always_comb begin
    if (neg_r) begin
      slot_val = slot_sub[IW] ? IW'(slot_sub + tdmast_pkg::SLOT_COUNT_X) : IW'(slot_sub);
    end else begin
      slot_val = (slot_add >= tdmast_pkg::SLOT_COUNT_X) ?
                 IW'(slot_add - tdmast_pkg::SLOT_COUNT_X) : IW'(slot_add);
    end
  end

  // saturate sign and magnitude to 32-bit two's complement
  assign sat_neg = off_neg_r && (off_mag_r != '0);
  always_comb begin
    if (sat_neg) begin
      sat_val = (off_mag_r >= TW'(33'h0_8000_0000)) ? 32'h8000_0000 : RW'(-off_mag_r);
    end else begin
      sat_val = (off_mag_r > TW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : RW'(off_mag_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= tdmast_pkg::PERIOD_RESET;
      lead   <= tdmast_pkg::LEAD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tdmast_pkg::REG_PERIOD: period <= cfg_data;
        tdmast_pkg::REG_LEAD:   lead   <= cfg_data;
        default: ;
      endcase
    end
  end

  // slot time and index
  always_ff @(posedge clk) begin
    if (rst) begin
      nst <= '0;
      idx <= '0;
    end else if (cmd.tick_diff) begin
      nst <= eff_time;
    end else if (cmd.tick_issue && go) begin
      nst <= nst + TW'(period);
      idx <= (idx == tdmast_pkg::SLOT_LAST) ? '0 : idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.rx_setup) begin
      cnt <= '0;
    end else if (cmd.div_step) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_cmd;
      now_r <= in_now;
    end
    if (cmd.tick_diff) begin
      d_r <= now_r - eff_time;
    end
    if (cmd.rx_diff) begin
      d_r <= now_r - nst;
    end
    if (cmd.rx_setup) begin
      neg_r  <= d_r[TW-1];
      mag_r  <= d_r[TW-1] ? -d_r : d_r;
      div_sh <= d_r[TW-1] ? -d_r : d_r;
      rem    <= '0;
      qm     <= '0;
    end
    if (cmd.div_step) begin
      div_sh <= {div_sh[TW-2:0], 1'b0};
      rem    <= rem_ge ? RW'(rem_s - {1'b0, period}) : RW'(rem_s);
      qm     <= qm_next;
    end
    if (cmd.rx_round) begin
      if (period == '0) begin
        qm        <= '0;
        off_neg_r <= neg_r;
        off_mag_r <= mag_r;
      end else if (rem_dbl >= {1'b0, period}) begin
        qm        <= (qm == tdmast_pkg::SLOT_LAST) ? '0 : qm + IW'(1);
        off_neg_r <= !neg_r;
        off_mag_r <= TW'(period - rem);
      end else begin
        off_neg_r <= neg_r;
        off_mag_r <= TW'(rem);
      end
    end
    if (cmd.tick_issue) begin
      res_issued <= go;
      res_start  <= go ? nst : '0;
      res_off    <= '0;
      slot_r     <= idx;
    end
    if (cmd.rx_slot) begin
      res_issued <= 1'b1;
      res_start  <= now_r;
      res_off    <= sat_val;
      slot_r     <= slot_val;
    end
    if (cmd.decode) begin
      res_num <= res_issued ? tdmast_pkg::slot_decode(slot_r) : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_issued <= res_issued;
      out_start  <= res_start;
      out_offset <= res_off;
      out_num    <= res_num;
    end
  end

  assign status.is_rx    = cmd_r;
  assign status.div_last = (cnt == '1);
  assign status.out_free = !out_valid || out_ready;

endmodule

FILE: tb/sv/tdma_slot_timing_tracker_unit_tb.sv
// ----------------------------------------------------------------------------
// tdma_slot_timing_tracker_unit_tb
// self-checking bench for the slot timing tracker: ticks and receive matching
// ----------------------------------------------------------------------------
// requests go through a bursty stream driver, results are taken by a monitor
// with its own stall pattern and checked against a slot timing predictor that
// runs at request accept. a directed part walks the slot time wrap, the lead
// time boundary, half period rounding, zero period and saturation; random
// phases then run under several period and lead settings.
module tdma_slot_timing_tracker_unit_tb;
  import tdmast_pkg::*;

  localparam logic [63:0] SLOT_SPAN  = 64'(SLOT_COUNT);
  localparam int          RAND_ITEMS = 144;
  localparam int          LIMIT_NS   = 6_000_000;

  // one request: command in tuser, time stamp in tdata
  typedef struct packed {
    logic        cmd;
    logic [63:0] now;
  } tdma_req_t;

  // one result, fields as the block reports them
  typedef struct packed {
    logic        issued;
    logic [63:0] start;
    logic [31:0] offset;
    logic [2:0]  ts;
    logic [4:0]  fr;
    logic [5:0]  mf;
  } slot_result_t;

  logic         clk;
  logic         rst           = 1'b1;
  logic         cfg_we        = 1'b0;
  logic         cfg_index     = REG_PERIOD;
  logic [31:0]  cfg_data      = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata  = '0;  // now_ns[63:0]
  logic [0:0]   s_axis_tuser  = '0;  // command[0]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // slot_start_ns[63:0], offset_ns[95:64], timeslot_number[98:96],
  // frame_number[103:99], multiframe_number[109:104], zero[111:110]
  logic [111:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;        // slot_issued[0]

  // predictor copy of registers and tracker state
  logic [31:0]      period_ns = PERIOD_RESET;
  logic [31:0]      lead_ns   = LEAD_RESET;
  logic [63:0]      trk_time  = '0;
  logic [IDX_W-1:0] trk_idx   = '0;

  tdma_req_t    req_q[$];
  slot_result_t slot_exp_q[$];

  int n_queued   = 0;
  int n_accepted = 0;
  int n_checked  = 0;
  int n_tick     = 0;
  int n_early    = 0;
  int n_rx       = 0;
  int n_cfg      = 0;
  int errors     = 0;

  int       gap_left   = 0;
  int       burst_left = 0;
  logic [9:0] rdy_cyc  = '0;

  tdma_slot_timing_tracker_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout: %0d of %0d results checked", n_checked, n_queued);
    $display("DONE: errors detected");
    $finish;
  end

  // expected result of one request, advances the tracker state
  function automatic slot_result_t predict_slot(input logic cmd, input logic [63:0] now);
    slot_result_t res;
    logic [63:0]  diff, mag, p, q, r, qm, slot, off_mag;
    logic         neg, off_neg;
    res = '0;
    slot = 64'(trk_idx);
    if (cmd == CMD_TICK) begin
      // first tick, or slot time wrapped to zero: timing restarts here
      if (trk_time == 64'd0)
        trk_time = now;
      diff = now - trk_time;
      // too early unless now + lead reaches the slot start
      if (diff[63] && (64'd0 - diff) > 64'(lead_ns))
        return res;
      res.issued = 1'b1;
      res.start  = trk_time;
      trk_time   = trk_time + 64'(period_ns);
      trk_idx    = IDX_W'((slot + 64'd1) % SLOT_SPAN);
    end else begin
      diff = now - trk_time;
      neg  = diff[63];
      mag  = neg ? 64'd0 - diff : diff;
      p    = 64'(period_ns);
      if (p == 64'd0) begin
        // zero period: no slot step, the whole difference is the offset
        q       = 64'd0;
        off_neg = neg;
        off_mag = mag;
      end else begin
        q = mag / p;
        r = mag % p;
        // half way rounds away from zero
        if (r >= p - r) begin
          q       = q + 64'd1;
          off_neg = !neg;
          off_mag = p - r;
        end else begin
          off_neg = neg;
          off_mag = r;
        end
      end
      qm   = q % SLOT_SPAN;
      slot = neg ? (slot + SLOT_SPAN - qm) % SLOT_SPAN : (slot + qm) % SLOT_SPAN;
      res.issued = 1'b1;
      res.start  = now;
      // saturate to 32-bit signed
      if (off_neg && off_mag != 64'd0)
        res.offset = (off_mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - off_mag);
      else
        res.offset = (off_mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(off_mag);
    end
    res.ts = 3'(slot % 64'(TSLOTS)) + 3'd1;
    res.fr = 5'((slot / 64'(TSLOTS)) % 64'(FRAMES)) + 5'd1;
    res.mf = 6'(slot / 64'(TSLOTS * FRAMES) + 64'd1);
    return res;
  endfunction

  function automatic logic [63:0] rand_time();
    return {$urandom, $urandom};
  endfunction

  task automatic note_error(input string msg);
    if (errors < 10)
      $display("%s", msg);
    errors++;
  endtask

  task automatic queue_req(input logic cmd, input logic [63:0] now);
    tdma_req_t req;
    req.cmd = cmd;
    req.now = now;
    req_q.push_back(req);
    n_queued++;
  endtask

  // block idle: every request taken and every result back
  task automatic wait_idle();
    while (n_accepted != n_queued || n_checked != n_accepted)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PERIOD)
      period_ns = val;
    else
      lead_ns = val;
    n_cfg++;
  endtask

  // random traffic around a moving time cursor from the slot time, else a random time
  task automatic random_phase(input int n_items);
    logic [63:0] cur, span, now;
    longint      off;
    int          k, sel;
    cur = trk_time;
    if (cur == 64'd0)
      cur = rand_time();
    span = (period_ns == 32'd0) ? 64'd1000 : 64'(period_ns);
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        // time moves on by up to one and a half slots, so early and late ticks mix
        cur = cur + span * $urandom_range(0, 150) / 100;
        now = ($urandom_range(0, 19) == 0) ? rand_time() : cur;
        queue_req(CMD_TICK, now);
      end else begin
        if (sel < 60) begin
          now = rand_time();
        end else begin
          // far matches wrap the slot index, near ones stay within a few slots
          if (sel < 70)
            k = int'($urandom_range(0, 12000)) - 6000;
          else
            k = int'($urandom_range(0, 6)) - 3;
          if (sel < 80)
            off = longint'(k) * longint'(span)
                + longint'(span / 2) * (($urandom_range(0, 1) == 1) ? 1 : -1);
          else
            off = longint'(k) * longint'(span)
                + longint'({32'd0, $urandom} % (2 * span + 64'd1)) - longint'(span);
          now = cur + off;
        end
        queue_req(CMD_RX, now);
      end
    end
  endtask

  // request driver: bursts of random length, random gaps between them
  always @(posedge clk) begin : drive
    slot_result_t res;
    tdma_req_t    req;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        res = predict_slot(s_axis_tuser[0], s_axis_tdata);
        slot_exp_q.push_back(res);
        n_accepted++;
        if (s_axis_tuser[0] == CMD_RX) begin
          n_rx++;
        end else begin
          n_tick++;
          if (!res.issued)
            n_early++;
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (req_q.size() != 0) begin
          req = req_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= req.now;
          s_axis_tuser  <= req.cmd;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 16);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor: check against the oldest expectation, stall on a pattern
  always @(posedge clk) begin : watch
    slot_result_t want, got;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      rdy_cyc <= rdy_cyc + 10'd1;
      if (m_axis_tvalid && m_axis_tready) begin
        got.issued = m_axis_tuser[0];
        got.start  = m_axis_tdata[63:0];
        got.offset = m_axis_tdata[95:64];
        got.ts     = m_axis_tdata[98:96];
        got.fr     = m_axis_tdata[103:99];
        got.mf     = m_axis_tdata[109:104];
        if (slot_exp_q.size() == 0) begin
          note_error($sformatf("unexpected result: issued=%0d start=%h", got.issued,
                               got.start));
        end else begin
          want = slot_exp_q.pop_front();
          n_checked++;
          if (got != want)
            note_error($sformatf(
              "mismatch %0d: exp %0d %h %0d %0d/%0d/%0d got %0d %h %0d %0d/%0d/%0d",
              n_checked, want.issued, want.start, $signed(want.offset), want.ts,
              want.fr, want.mf, got.issued, got.start, $signed(got.offset), got.ts,
              got.fr, got.mf));
        end
      end
      // stall mode is picked by the top two bits of the cycle counter
      case (rdy_cyc[9:8])
        2'd0:    m_axis_tready <= 1'b1;
        2'd1:    m_axis_tready <= ($urandom_range(0, 9) < 7);
        2'd2:    m_axis_tready <= ($urandom_range(0, 9) < 3);
        default: m_axis_tready <= (rdy_cyc[2:0] == 3'd0);
      endcase
    end
  end

  initial begin : stimulus
    logic [63:0] p, l, w, n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: receive before start, slot time wrap, lead boundary
    p = 64'(PERIOD_RESET);
    l = 64'(LEAD_RESET);
    w = 64'd0 - 3 * p;
    queue_req(CMD_RX, 64'd0);
    queue_req(CMD_RX, '1);
    queue_req(CMD_RX, 64'h8000_0000_0000_0000);
    queue_req(CMD_TICK, w);                  // starts timing
    queue_req(CMD_TICK, w + 64'd1);          // early
    queue_req(CMD_TICK, w + p - l);          // exactly at lead time
    queue_req(CMD_TICK, w + 2 * p - l - 1);  // one short of lead time
    queue_req(CMD_RX, w + 2 * p + p / 2);    // half period after
    queue_req(CMD_RX, w + 2 * p - p / 2);    // half period before
    queue_req(CMD_TICK, w + 2 * p);          // slot time wraps to zero
    queue_req(CMD_TICK, 64'd1_000_000_000);  // restarts timing
    queue_req(CMD_RX, 64'd1_000_000_000 + 5001 * p);
    queue_req(CMD_TICK, '1);
    queue_req(CMD_RX, 64'd1);
    wait_idle();

    // zero period, zero lead: saturation both ways, no slot step
    write_reg(REG_PERIOD, 32'd0);
    write_reg(REG_LEAD, 32'd0);
    n = trk_time;
    queue_req(CMD_RX, n + 64'h100_0000_0000);
    queue_req(CMD_RX, n - 64'h100_0000_0000);
    queue_req(CMD_RX, n - 64'd5);
    queue_req(CMD_TICK, n - 64'd1);
    queue_req(CMD_TICK, n);
    queue_req(CMD_TICK, n + 64'd7);
    wait_idle();

    // largest period and lead, odd period half way cases
    write_reg(REG_PERIOD, 32'hFFFF_FFFF);
    write_reg(REG_LEAD, 32'hFFFF_FFFF);
    n = trk_time;
    queue_req(CMD_RX, n + 64'h8000_0000);
    queue_req(CMD_RX, n + 64'h7FFF_FFFF);
    queue_req(CMD_TICK, n - 64'hFFFF_FFFF);
    queue_req(CMD_TICK, n + 64'd3);
    wait_idle();

    // random phases over a spread of settings
    write_reg(REG_PERIOD, PERIOD_RESET);
    write_reg(REG_LEAD, LEAD_RESET);
    random_phase(RAND_ITEMS);
    wait_idle();
    write_reg(REG_PERIOD, 32'd1000);
    write_reg(REG_LEAD, 32'd0);
    random_phase(RAND_ITEMS);
    wait_idle();
    write_reg(REG_PERIOD, $urandom_range(1, 1000));
    write_reg(REG_LEAD, $urandom_range(0, 1000));
    random_phase(RAND_ITEMS);
    wait_idle();
    write_reg(REG_PERIOD, 32'hFFFF_FFFF);
    write_reg(REG_LEAD, 32'hFFFF_FFFF);
    random_phase(RAND_ITEMS);
    wait_idle();
    write_reg(REG_PERIOD, $urandom);
    write_reg(REG_LEAD, $urandom);
    random_phase(RAND_ITEMS);
    wait_idle();
    write_reg(REG_PERIOD, 32'd1);
    write_reg(REG_LEAD, $urandom_range(0, 3));
    random_phase(RAND_ITEMS);
    wait_idle();
    write_reg(REG_PERIOD, 32'd0);
    write_reg(REG_LEAD, $urandom_range(0, 5000));
    random_phase(RAND_ITEMS);
    wait_idle();
    // lead longer than the period
    p = 64'($urandom_range(1_000_000, 20_000_000));
    write_reg(REG_PERIOD, 32'(p));
    write_reg(REG_LEAD, 32'(2 * p));
    random_phase(RAND_ITEMS);

    // drain, then let the pipeline settle past a receive latency
    wait_idle();
    repeat (80) @(posedge clk);
    if (slot_exp_q.size() != 0)
      note_error($sformatf("%0d results never arrived", slot_exp_q.size()));
    $display("ran %0d ticks (%0d early) and %0d receive matches over %0d register writes",
             n_tick, n_early, n_rx, n_cfg);
    $display("%0d results checked, %0d errors", n_checked, errors);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
